/* design/atp_pkg.sv */
// ----------------------------------------------------------------------------
// atp_pkg: shared types and constants of the tone picker
// Operation codes, register indexes, divider and scanner interfaces, noise table.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int unsigned NumWidth   = 18;  // dividend width, holds 131072
  localparam int unsigned DenWidth   = 20;  // divisor width, holds 112 << 13
  localparam int unsigned NumNibbles = 32;
  localparam int unsigned WaveBits   = 4 * NumNibbles;

  localparam logic [NumWidth-1:0] SqNum    = 18'd131072;
  localparam logic [NumWidth-1:0] WaveNum  = 18'd65536;
  // 4194304 / d / 128 folds to 32768 / d
  localparam logic [NumWidth-1:0] NoiseNum = 18'd32768;

  localparam logic [11:0] PeriodSpan      = 12'd2048;
  localparam logic [3:0]  NoiseShiftLimit = 4'd14;

  localparam logic [1:0] OpService = 2'd0;
  localparam logic [1:0] OpFlush   = 2'd1;
  localparam logic [1:0] OpPause   = 2'd2;

  localparam logic [1:0] RegOutEn  = 2'd0;
  localparam logic [1:0] RegMinHz  = 2'd1;
  localparam logic [1:0] RegMaxHz  = 2'd2;

  localparam logic [1:0] ChSquare1 = 2'd0;
  localparam logic [1:0] ChSquare2 = 2'd1;
  localparam logic [1:0] ChWave    = 2'd2;
  localparam logic [1:0] ChNoise   = 2'd3;

  localparam logic [1:0] PtrReset  = 2'd3;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StSel   = 5'b00010,
    StDiv   = 5'b00100,
    StCheck = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  typedef struct packed {
    logic                start;
    logic [NumWidth-1:0] num;
    logic [DenWidth-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [NumWidth-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic       done;
    logic [2:0] mul_shift;  // log2 of the repetition multiplier
  } scan_rsp_t;

  function automatic logic [6:0] noise_div(input logic [2:0] code);
    logic [6:0] d;
    case (code)
      3'd0:    d = 7'd8;
      3'd1:    d = 7'd16;
      3'd2:    d = 7'd32;
      3'd3:    d = 7'd48;
      3'd4:    d = 7'd64;
      3'd5:    d = 7'd80;
      3'd6:    d = 7'd96;
      default: d = 7'd112;
    endcase
    return d;
  endfunction

endpackage

/* design/atp_div.sv */
// ----------------------------------------------------------------------------
// atp_div: bit-serial restoring divider
// One quotient bit per cycle, dividend shifted in MSB first.
// ----------------------------------------------------------------------------
module atp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atp_pkg::div_req_t req_i,
  output atp_pkg::div_rsp_t rsp_o
);
  import atp_pkg::*;

  localparam int unsigned CntW = $clog2(NumWidth);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [NumWidth-1:0] num_q, quot_q;
  logic [DenWidth-1:0] den_q, rem_q;
  logic [DenWidth:0]   trial, diff;
  logic                ge;

  assign trial = {rem_q, num_q[NumWidth-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NumWidth - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NumWidth-2:0], 1'b0};
      rem_q  <= ge ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
      quot_q <= {quot_q[NumWidth-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* design/atp_wscan.sv */
// ----------------------------------------------------------------------------
// atp_wscan: wave table repetition scanner
// Shifts the 32 nibbles past four comparators, one nibble per cycle.
// ----------------------------------------------------------------------------
module atp_wscan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [atp_pkg::WaveBits-1:0]  wave_i,
  output atp_pkg::scan_rsp_t            rsp_o
);
  import atp_pkg::*;

  localparam int unsigned PosW = $clog2(NumNibbles);

  logic [WaveBits-1:0] nib_q;
  logic [PosW-1:0]     pos_q;
  logic                busy_q, done_q;
  logic [3:0]          miss_q, miss_now;
  logic [3:0]          head;
  logic [2:0]          mul_shift;

  assign head = nib_q[WaveBits-1 -: 4];

  // lag p = 2 << j; only pairs whose partner lies inside the table count
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      miss_now[j] = (head != nib_q[WaveBits-1-4*(2<<j) -: 4]) &&
                    (pos_q < PosW'(NumNibbles - (2 << j)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pos_q  <= '0;
      miss_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      pos_q  <= '0;
      miss_q <= '0;
    end else if (busy_q) begin
      miss_q <= miss_q | miss_now;
      pos_q  <= pos_q + 1'b1;
      if (pos_q == PosW'(NumNibbles - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      nib_q <= wave_i;
    end else if (busy_q) begin
      nib_q <= {nib_q[WaveBits-5:0], 4'h0};
    end
  end

  always_comb begin
    if (!miss_q[0]) begin
      mul_shift = 3'd4;
    end else if (!miss_q[1]) begin
      mul_shift = 3'd3;
    end else if (!miss_q[2]) begin
      mul_shift = 3'd2;
    end else if (!miss_q[3]) begin
      mul_shift = 3'd1;
    end else begin
      mul_shift = 3'd0;
    end
  end

  assign rsp_o.mul_shift = mul_shift;
  assign rsp_o.done      = done_q;

endmodule

/* design/apu_tone_picker_top.sv */
// ----------------------------------------------------------------------------
// apu_tone_picker_top: per-frame tone picker for one square-wave output
// Round-robin over four channel snapshots, shared serial divider, APB registers.
// ----------------------------------------------------------------------------
// With the output enabled, flush and pause words load the result register, and the
// emit state then loads the output word once the output register is free. Service
// frame: select alone for a silent channel; select, divider steps, handover, check
// for a divided one; then the emit state loads the output and returns to idle.
// A wave channel checked before the 32-nibble scan is through waits in check for it.
// Reset: pointer to 3, registers to their reset values, no result pending.
module apu_tone_picker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  chan_active_i,
  input  logic [10:0] square1_period_i,
  input  logic [10:0] square2_period_i,
  input  logic [10:0] wave_period_i,
  input  logic [3:0]  noise_shift_i,
  input  logic [2:0]  noise_divisor_code_i,
  input  logic [63:0] wave_ram_high_i,
  input  logic [63:0] wave_ram_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tone_on_o,
  output logic [15:0] tone_hz_o,
  output logic [1:0]  source_channel_o
);
  import atp_pkg::*;

  localparam int unsigned ToneW = NumWidth + 3;

  // configuration
  logic        oe_q;
  logic [15:0] min_q, max_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oe_q  <= 1'b0;
      min_q <= 16'd65;
      max_q <= 16'd16000;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegOutEn: oe_q  <= pwdata[0];
        RegMinHz: min_q <= pwdata[15:0];
        RegMaxHz: max_q <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegOutEn: prdata = {31'b0, oe_q};
      RegMinHz: prdata = {16'b0, min_q};
      RegMaxHz: prdata = {16'b0, max_q};
      default:  prdata = '0;
    endcase
  end

  // sequencer
  state_e      st_q, st_d;
  logic [1:0]  ptr_q, ptr_d, cur_q, cur_d, cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc, out_load, res_load;
  logic        res_on_d;
  logic [15:0] res_hz_d;
  logic [1:0]  res_src_d;

  // snapshot and result words
  logic [3:0]  active_q;
  logic [10:0] sq1_q, sq2_q, wper_q;
  logic [3:0]  nsh_q;
  logic [2:0]  ncode_q;
  logic        res_on_q, out_on_q;
  logic [15:0] res_hz_q, out_hz_q;
  logic [1:0]  res_src_q, out_src_q;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  scan_rsp_t scan_rsp;
  logic      scan_load;
  logic      div_start;

  logic             chan_live, fits, advance;
  logic [ToneW-1:0] tone;

  assign in_ready_o = (st_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  atp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  atp_wscan u_wscan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (scan_load),
    .wave_i ({wave_ram_high_i, wave_ram_low_i}),
    .rsp_o  (scan_rsp)
  );

  assign chan_live = active_q[cur_q] && !(cur_q == ChNoise && nsh_q >= NoiseShiftLimit);

  always_comb begin
    div_req.start = div_start;
    case (cur_q)
      ChSquare1: begin
        div_req.num = SqNum;
        div_req.den = DenWidth'(PeriodSpan - {1'b0, sq1_q});
      end
      ChSquare2: begin
        div_req.num = SqNum;
        div_req.den = DenWidth'(PeriodSpan - {1'b0, sq2_q});
      end
      ChWave: begin
        div_req.num = WaveNum;
        div_req.den = DenWidth'(PeriodSpan - {1'b0, wper_q});
      end
      default: begin
        div_req.num = NoiseNum;
        div_req.den = DenWidth'(noise_div(ncode_q)) << nsh_q;
      end
    endcase
  end

  assign tone = (cur_q == ChWave) ? (ToneW'(div_rsp.quot) << scan_rsp.mul_shift)
                                  : ToneW'(div_rsp.quot);
  assign fits = (tone != '0) && (tone >= ToneW'(min_q)) && (tone <= ToneW'(max_q));

  always_comb begin
    st_d        = st_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    res_load    = 1'b0;
    res_on_d    = 1'b0;
    res_hz_d    = '0;
    res_src_d   = '0;
    out_load    = 1'b0;
    scan_load   = 1'b0;
    div_start   = 1'b0;
    advance     = 1'b0;

    case (st_q)
      StIdle: begin
        if (in_acc) begin
          case (operation_i)
            OpFlush: begin
              ptr_d = PtrReset;
              if (oe_q) begin
                res_load = 1'b1;
                st_d     = StEmit;
              end
            end
            OpPause: begin
              if (oe_q) begin
                res_load = 1'b1;
                st_d     = StEmit;
              end
            end
            OpService: begin
              if (oe_q) begin
                ptr_d     = ptr_q + 1'b1;
                cur_d     = ptr_q + 1'b1;
                cnt_d     = '0;
                scan_load = 1'b1;
                st_d      = StSel;
              end
            end
            default: ;
          endcase
        end
      end
      StSel: begin
        if (chan_live) begin
          div_start = 1'b1;
          st_d      = StDiv;
        end else begin
          advance = 1'b1;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          st_d = StCheck;
        end
      end
      StCheck: begin
        if (cur_q != ChWave || scan_rsp.done) begin
          if (fits) begin
            res_load  = 1'b1;
            res_on_d  = 1'b1;
            res_hz_d  = tone[15:0];
            res_src_d = cur_q;
            st_d      = StEmit;
          end else begin
            advance = 1'b1;
          end
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase

    // last of four channels falls through to silence
    if (advance) begin
      if (cnt_q == 2'd3) begin
        res_load = 1'b1;
        st_d     = StEmit;
      end else begin
        cnt_d = cnt_q + 1'b1;
        cur_d = cur_q + 1'b1;
        st_d  = StSel;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      ptr_q       <= PtrReset;
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ptr_q       <= ptr_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      active_q <= chan_active_i;
      sq1_q    <= square1_period_i;
      sq2_q    <= square2_period_i;
      wper_q   <= wave_period_i;
      nsh_q    <= noise_shift_i;
      ncode_q  <= noise_divisor_code_i;
    end
    if (res_load) begin
      res_on_q  <= res_on_d;
      res_hz_q  <= res_hz_d;
      res_src_q <= res_src_d;
    end
    if (out_load) begin
      out_on_q  <= res_on_q;
      out_hz_q  <= res_hz_q;
      out_src_q <= res_src_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tone_on_o        = out_on_q;
  assign tone_hz_o        = out_hz_q;
  assign source_channel_o = out_src_q;

  a_tone_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tone_on_o) |->
      (tone_hz_o != 16'd0 && tone_hz_o >= min_q && tone_hz_o <= max_q))
    else $error("tone outside limits");

  a_silent_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tone_on_o) |-> (tone_hz_o == 16'd0 && source_channel_o == 2'd0))
    else $error("silent word carries data");

  a_flush_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OpFlush) |=> (ptr_q == PtrReset))
    else $error("flush left pointer");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> !div_rsp.busy)
    else $error("divider busy in idle");

endmodule

/* bench/apu_tone_picker_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// apu_tone_picker_top_tb: self-checking bench for the per-frame tone picker
// Drives frame snapshots, flushes and pauses over valid/ready, sets the output
// enable and tone limits over APB while the block is idle, and checks every result
// word against an in-bench round-robin model, or a typed row against its plan entry.
// ----------------------------------------------------------------------------
module apu_tone_picker_top_tb;
  import atp_pkg::*;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam int unsigned SquareClk    = 131072;
  localparam int unsigned WaveClk      = 65536;
  localparam int unsigned NoiseClk     = 4194304;
  localparam int unsigned NoisePostDiv = 128;
  localparam int unsigned PeriodRange  = 2048;
  localparam int unsigned ShiftSilent  = 14;
  localparam int unsigned SettleCycles = 150;   // slowest frame plus nibble scan
  localparam int unsigned StuckLimit   = 3000;
  localparam int unsigned ShowLimit    = 20;

  typedef enum logic [2:0] {
    WvZero, WvOnes, WvRep4, WvRep8, WvRep16, WvNoRep, WvRep2, WvBroken
  } wave_pick_e;

  typedef struct packed {
    logic [1:0]   op;
    logic [3:0]   active;
    logic [10:0]  sq1;
    logic [10:0]  sq2;
    logic [10:0]  wv;
    logic [3:0]   nshift;
    logic [2:0]   ncode;
    logic [127:0] wave;
  } tone_frame_t;

  typedef struct packed {
    logic        on;
    logic [15:0] hz;
    logic [1:0]  ch;
  } tone_result_t;

  // typed rows always expect either nothing or one silent word
  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  op;
    logic [3:0]  active;
    logic [10:0] sq1;
    logic [10:0] sq2;
    logic [10:0] wv;
    logic [3:0]  nshift;
    logic [2:0]  ncode;
    wave_pick_e  wsel;
    logic        typed;
    logic        t_has;
  } plan_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i          = OpService;
  logic [3:0]  chan_active_i        = '0;
  logic [10:0] square1_period_i     = '0;
  logic [10:0] square2_period_i     = '0;
  logic [10:0] wave_period_i        = '0;
  logic [3:0]  noise_shift_i        = '0;
  logic [2:0]  noise_divisor_code_i = '0;
  logic [63:0] wave_ram_high_i      = '0;
  logic [63:0] wave_ram_low_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        tone_on_o;
  logic [15:0] tone_hz_o;
  logic [1:0]  source_channel_o;

  apu_tone_picker_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .operation_i, .chan_active_i, .square1_period_i,
    .square2_period_i, .wave_period_i, .noise_shift_i, .noise_divisor_code_i,
    .wave_ram_high_i, .wave_ram_low_i, .out_valid_o, .out_ready_i, .tone_on_o,
    .tone_hz_o, .source_channel_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of block state and registers
  logic        cfg_oe     = 1'b0;
  logic [15:0] cfg_min_hz = 16'd65;
  logic [15:0] cfg_max_hz = 16'd16000;
  logic [1:0]  rr_ptr     = PtrReset;

  tone_result_t pending_tones [$];
  int unsigned  noise_steps [8] = '{8, 16, 32, 48, 64, 80, 96, 112};

  logic        idle_on   = 1'b1;
  logic        row_typed = 1'b0;
  logic        row_has   = 1'b0;
  int unsigned mismatches, words_taken, tones_heard, silences_heard, settings_used;
  int unsigned stuck_cycles, stall_left;

  plan_row_t plan [27] = '{
    '{2'd0, OpService, 4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b0},
    '{2'd0, OpFlush,   4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b0},
    '{2'd0, OpPause,   4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b0},
    '{2'd0, OpUnused,  4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b0},
    '{2'd1, OpFlush,   4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b1},
    '{2'd1, OpPause,   4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b1},
    '{2'd1, OpUnused,  4'hF, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b0},
    '{2'd1, OpService, 4'h0, 11'd1000, 11'd1500, 11'd1800, 4'd2, 3'd1, WvZero, 1'b1, 1'b1},
    '{2'd1, OpService, 4'h1, 11'd2047, 11'd0,    11'd0,    4'd0, 3'd0, WvZero, 1'b1, 1'b1},
    '{2'd1, OpService, 4'h1, 11'd0,    11'd0,    11'd0,    4'd0, 3'd0, WvZero, 1'b1, 1'b1},
    '{2'd1, OpService, 4'hF, 11'd1024, 11'd1536, 11'd1792, 4'd0, 3'd0, WvZero, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd2047, 4'd0, 3'd0, WvNoRep, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd1024, 4'd0, 3'd0, WvRep4, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd1024, 4'd0, 3'd0, WvRep8, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd1024, 4'd0, 3'd0, WvRep16, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd1024, 4'd0, 3'd0, WvBroken, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd1024, 4'd0, 3'd0, WvRep2, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h8, 11'd0,    11'd0,    11'd0,    4'd14, 3'd0, WvZero, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h8, 11'd0,    11'd0,    11'd0,    4'd15, 3'd7, WvZero, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h8, 11'd0,    11'd0,    11'd0,    4'd13, 3'd7, WvZero, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h8, 11'd0,    11'd0,    11'd0,    4'd0,  3'd7, WvZero, 1'b0, 1'b0},
    '{2'd1, OpService, 4'h4, 11'd0,    11'd0,    11'd0,    4'd0,  3'd0, WvOnes, 1'b0, 1'b0},
    '{2'd2, OpService, 4'h0, 11'd2047, 11'd2047, 11'd2047, 4'd0, 3'd0, WvOnes, 1'b1, 1'b1},
    '{2'd2, OpService, 4'h3, 11'd2046, 11'd2045, 11'd0,    4'd0, 3'd0, WvZero, 1'b0, 1'b0},
    '{2'd2, OpFlush,   4'hF, 11'd0,    11'd0,    11'd0,    4'd0, 3'd0, WvZero, 1'b1, 1'b1},
    '{2'd3, OpService, 4'hF, 11'd1024, 11'd1536, 11'd1792, 4'd0, 3'd0, WvZero, 1'b1, 1'b1},
    '{2'd3, OpPause,   4'hF, 11'd1024, 11'd1536, 11'd1792, 4'd0, 3'd0, WvZero, 1'b1, 1'b1}
  };
  logic        dir_oe  [4] = '{1'b0, 1'b1, 1'b1, 1'b1};
  logic [15:0] dir_min [4] = '{16'd65, 16'd65, 16'd0, 16'd65535};
  logic [15:0] dir_max [4] = '{16'd16000, 16'd16000, 16'd65535, 16'd0};

  // ---------------------------------------------------------------- model

  function automatic int unsigned repeat_factor(input logic [127:0] w);
    int unsigned p;
    logic        same;
    for (int k = 0; k < 4; k++) begin
      p    = 2 << k;
      same = 1'b1;
      for (int i = 0; i + p < 32; i++) begin
        if (w[127-4*i -: 4] != w[127-4*(i+p) -: 4]) same = 1'b0;
      end
      if (same) return 32 / p;
    end
    return 1;
  endfunction

  // tone of one channel, zero when inactive, when the noise shift silences it, or outside the limits
  function automatic int unsigned chan_tone(input logic [1:0] ch, input tone_frame_t f);
    int unsigned hz, per, step;
    hz = 0;
    if (f.active[ch]) begin
      case (ch)
        ChSquare1: begin
          per = 32'(f.sq1);
          hz  = SquareClk / (PeriodRange - per);
        end
        ChSquare2: begin
          per = 32'(f.sq2);
          hz  = SquareClk / (PeriodRange - per);
        end
        ChWave: begin
          per = 32'(f.wv);
          hz  = (WaveClk / (PeriodRange - per)) * repeat_factor(f.wave);
        end
        default: begin
          if (f.nshift < ShiftSilent) begin
            step = noise_steps[f.ncode] << f.nshift;
            hz   = (NoiseClk / step) / NoisePostDiv;
          end
        end
      endcase
    end
    if (hz >= cfg_min_hz && hz <= cfg_max_hz) return hz;
    return 0;
  endfunction

  // advances the pointer mirror on a served word, resets it on a flush; returns 1 when the word yields a result
  function automatic logic pick_tone(input tone_frame_t f, output tone_result_t r);
    logic [1:0]  ch;
    int unsigned hz;
    r = '0;
    if (f.op == OpFlush) begin
      rr_ptr = PtrReset;
      return cfg_oe;
    end
    if (f.op == OpPause) return cfg_oe;
    if (f.op != OpService || !cfg_oe) return 1'b0;
    rr_ptr = rr_ptr + 2'd1;
    for (int k = 0; k < 4; k++) begin
      ch = rr_ptr + k[1:0];
      hz = chan_tone(ch, f);
      if (hz != 0) begin
        r.on = 1'b1;
        r.hz = hz[15:0];
        r.ch = ch;
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what);
    if (mismatches < ShowLimit) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    tone_frame_t  got;
    tone_result_t want, seen;
    logic         has, in_fire, out_fire, apb_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    apb_fire = psel && penable && pwrite && pready;

    if (out_fire) begin
      seen = {tone_on_o, tone_hz_o, source_channel_o};
      if (pending_tones.size() == 0) begin
        flag_mismatch($sformatf("unexpected word on=%0b hz=%0d ch=%0d",
                                seen.on, seen.hz, seen.ch));
      end else begin
        want = pending_tones.pop_front();
        if (seen.on !== want.on)
          flag_mismatch($sformatf("tone_on %0b, want %0b", seen.on, want.on));
        if (seen.hz !== want.hz)
          flag_mismatch($sformatf("tone_hz %0d, want %0d", seen.hz, want.hz));
        if (seen.ch !== want.ch)
          flag_mismatch($sformatf("source_channel %0d, want %0d", seen.ch, want.ch));
      end
      if (seen.on === 1'b1) tones_heard++;
      else silences_heard++;
    end

    // result side first: a result leaving now belongs to an older word
    if (in_fire) begin
      got.op     = operation_i;
      got.active = chan_active_i;
      got.sq1    = square1_period_i;
      got.sq2    = square2_period_i;
      got.wv     = wave_period_i;
      got.nshift = noise_shift_i;
      got.ncode  = noise_divisor_code_i;
      got.wave   = {wave_ram_high_i, wave_ram_low_i};
      has = pick_tone(got, want);
      if (row_typed) begin
        has  = row_has;
        want = '0;
      end
      if (has) pending_tones.push_back(want);
      words_taken++;
    end

    if (apb_fire) begin
      case (paddr[3:2])
        RegOutEn: cfg_oe     = pwdata[0];
        RegMinHz: cfg_min_hz = pwdata[15:0];
        RegMaxHz: cfg_max_hz = pwdata[15:0];
        default: ;
      endcase
    end

    if (in_fire || out_fire || apb_fire) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("[%0t] no progress for %0d cycles", $time, StuckLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure in random-length bursts, started only while idle_on is set
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_word(input tone_frame_t f, input logic typed, input logic has);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    operation_i          <= f.op;
    chan_active_i        <= f.active;
    square1_period_i     <= f.sq1;
    square2_period_i     <= f.sq2;
    wave_period_i        <= f.wv;
    noise_shift_i        <= f.nshift;
    noise_divisor_code_i <= f.ncode;
    wave_ram_high_i      <= f.wave[127:64];
    wave_ram_low_i       <= f.wave[63:0];
    row_typed            <= typed;
    row_has              <= has;
    in_valid_i           <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // words that yield nothing may still be in flight once the queue empties
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic oe, input logic [15:0] lo,
                                input logic [15:0] hi);
    drain_block();
    apb_write(RegOutEn, {31'd0, oe});
    apb_write(RegMinHz, {16'd0, lo});
    apb_write(RegMaxHz, {16'd0, hi});
    settings_used++;
  endtask

  initial begin : stim
    tone_frame_t f;
    logic [1:0]  cur_phase;
    logic [3:0]  motif [16];
    logic [3:0]  flip;
    logic [15:0] lo, hi;
    int unsigned pick, rep, p, idx, counted, n;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: phase 0 runs on the reset values of the registers
    cur_phase = 2'd0;
    for (int r = 0; r < 27; r++) begin
      if (plan[r].phase != cur_phase) begin
        cur_phase = plan[r].phase;
        apply_settings(dir_oe[cur_phase], dir_min[cur_phase], dir_max[cur_phase]);
      end
      f.op     = plan[r].op;
      f.active = plan[r].active;
      f.sq1    = plan[r].sq1;
      f.sq2    = plan[r].sq2;
      f.wv     = plan[r].wv;
      f.nshift = plan[r].nshift;
      f.ncode  = plan[r].ncode;
      case (plan[r].wsel)
        WvZero:   f.wave = '0;
        WvOnes:   f.wave = '1;
        WvRep4:   f.wave = {8{16'h0123}};
        WvRep8:   f.wave = {4{32'h0123_4567}};
        WvRep16:  f.wave = {2{64'h0123_4567_89AB_CDEF}};
        WvNoRep:  f.wave = 128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210;
        WvRep2:   f.wave = {16{8'hA5}};
        default:  f.wave = {{7{16'h0123}}, 16'h0124};  // period 4, last nibble off
      endcase
      send_word(f, plan[r].typed, plan[r].t_has);
    end

    // random phases, each under fresh register settings
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          lo = 16'($urandom_range(0, 200));
          hi = 16'($urandom_range(2000, 65535));
        end
        1: begin
          lo = 16'($urandom_range(0, 2000));
          hi = 16'(lo + $urandom_range(0, 3000));
        end
        2: begin
          lo = 16'd0;
          hi = 16'hFFFF;
        end
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end
      endcase
      apply_settings(ph != 2, lo, hi);
      idle_on = (ph != 7);
      n       = (ph == 2) ? 30 : 110;
      counted = 0;
      while (counted < n) begin
        pick = $urandom_range(0, 99);
        f.op = (pick < 80) ? OpService : (pick < 89) ? OpFlush :
               (pick < 97) ? OpPause : OpUnused;
        f.active = 4'($urandom_range(0, 15));
        f.sq1    = 11'($urandom_range(0, 2047));
        f.sq2    = 11'($urandom_range(0, 2047));
        f.wv     = 11'($urandom_range(0, 2047));
        f.nshift = 4'($urandom_range(0, 15));
        f.ncode  = 3'($urandom_range(0, 7));
        // mostly repeating wave tables, some with one nibble spoilt
        rep = $urandom_range(0, 9);
        if (rep == 9) begin
          f.wave = {$urandom, $urandom, $urandom, $urandom};
        end else begin
          p = 2 << $urandom_range(0, 3);
          for (int i = 0; i < 16; i++) motif[i] = 4'($urandom_range(0, 15));
          for (int i = 0; i < 32; i++) f.wave[127-4*i -: 4] = motif[i % p];
          if (rep == 8) begin
            idx  = $urandom_range(0, 31);
            flip = 4'($urandom_range(1, 15));
            f.wave[127-4*idx -: 4] = f.wave[127-4*idx -: 4] ^ flip;
          end
        end
        send_word(f, 1'b0, 1'b0);
        if (f.op != OpUnused) counted++;
      end
    end

    drain_block();
    $display("run took %0d words under %0d register settings", words_taken,
             settings_used);
    $display("results seen: %0d tones, %0d silent", tones_heard, silences_heard);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* apu_tone_picker_top.f */
design/atp_pkg.sv
design/atp_div.sv
design/atp_wscan.sv
design/apu_tone_picker_top.sv
bench/apu_tone_picker_top_tb.sv
